>>> rtl/hog_pkg.sv
package hog_pkg;

    // Fixed point format of the angle and magnitude inputs.
    localparam int FRAC_BITS     = 7;
    localparam int MAX_CELL_SIDE = 64;

    localparam int MAG_W  = 16;
    localparam int ANG_W  = 16;
    localparam int SIDE_W = 7;
    localparam int CNT_W  = 12;
    localparam int ACC_W  = 40;
    localparam int IDX_W  = 4;

    localparam int NUM_BINS = 9;
    localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(NUM_BINS - 1);

    // One bin is 20 degrees, half a turn is 180 degrees.
    localparam int BIN_SPAN  = 20 << FRAC_BITS;
    localparam int HALF_TURN = 180 << FRAC_BITS;

    // Width of the in-bin fraction and of the weight (BIN_SPAN - fraction).
    localparam int FRAC_W = $clog2(BIN_SPAN + 1);
    localparam int PROD_W = MAG_W + FRAC_W;

    // Integer degrees of the folded angle and the coarse bin number.
    // floor(q * 205 / 4096) equals floor(q / 20) for every q below 512.
    localparam int Q_W         = ANG_W - FRAC_BITS;
    localparam int BIN_RECIP   = 205;
    localparam int RECIP_SHIFT = 12;
    localparam int RECIP_W     = Q_W + 8;
    localparam int BIN_W       = RECIP_W - RECIP_SHIFT;

    // Accumulator storage: one bank bit above the bin index.
    localparam int ADDR_W    = IDX_W + 1;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    // Result queue in front of the output port.
    localparam int OQ_DEPTH = 3;
    localparam int OQ_PTR_W = 2;

endpackage

>>> rtl/hog_cell_orientation_histogram_unit.sv
// HOG cell orientation histogram, nine unsigned bins of 20 degrees each.
// Every input transaction carries one pixel's gradient magnitude and angle,
// both with seven fraction bits. Angles of 180 degrees or more are folded
// down once by 180, and the magnitude is split linearly between the two
// nearest bins (bin 8 wraps to bin 0). Sums are exact, in units of one
// magnitude step over 2560. After cell_side squared pixels the block emits
// nine output transactions, bins 0 to 8 in order, with last_bin high on
// bin 8, and starts the next cell from zero. cell_side is clamped to 1..64.
// Throughput is one pixel per clock while in_stall is low: a pixel passes
// four pipeline stages (fold and coarse bin, fraction, weight multiplies
// with the memory read, add and write back) and the read-modify-write on
// the accumulator memory is forwarded, so back-to-back pixels in the same
// bin never wait. The accumulators live in two synchronous memories with
// two banks each, one bank per cell, so the next cell fills one bank while
// the finished cell is read out of the other at one bin per clock unless
// out_stall holds the output. in_stall rises only when the bank that the
// next pixel needs still holds a cell whose bins have not all been read
// out. With a ready consumer that readout ends before a cell of sixteen
// pixels or more (a side of four or more) has filled the other bank, so
// this never happens then, while smaller cells wait for the readout. No
// clearing pass is needed after reset: per-entry valid bits make untouched
// bins read as zero.
module hog_cell_orientation_histogram_unit
    import hog_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_wr_en,
    input  logic [SIDE_W-1:0]   cfg_wr_data,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic [MAG_W-1:0]    magnitude,
    input  logic [ANG_W-1:0]    orientation,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [IDX_W-1:0]    bin_index,
    output logic [ACC_W-1:0]    bin_sum,
    output logic                last_bin
);

    // ------------------------------------------------------------------
    // Configuration and pixel counting
    // ------------------------------------------------------------------
    logic [SIDE_W-1:0]   cell_side_reg;
    logic [CNT_W-1:0]    pix_cnt_reg, pix_cnt_next;
    logic                cur_bank_reg;
    logic [1:0]          bank_full_reg;
    logic [1:0]          done_reg;

    logic [SIDE_W-1:0]   side_eff;
    logic [2*SIDE_W-1:0] target;
    logic [2*SIDE_W-1:0] cnt_plus;
    logic                in_accept;
    logic                in_last;

    always_comb
    begin
        priority if (cell_side_reg == '0)
            side_eff = SIDE_W'(1);
        else if (cell_side_reg > SIDE_W'(MAX_CELL_SIDE))
            side_eff = SIDE_W'(MAX_CELL_SIDE);
        else
            side_eff = cell_side_reg;
    end

    assign target    = (2*SIDE_W)'(side_eff) * (2*SIDE_W)'(side_eff);
    assign cnt_plus  = (2*SIDE_W)'(pix_cnt_reg) + (2*SIDE_W)'(1);
    assign in_last   = (cnt_plus >= target);
    assign in_stall  = bank_full_reg[cur_bank_reg];
    assign in_accept = in_valid && !in_stall;
    assign pix_cnt_next = in_last ? '0 : cnt_plus[CNT_W-1:0];

    // ------------------------------------------------------------------
    // Stage 1: fold the angle and find the coarse bin
    // ------------------------------------------------------------------
    logic [ANG_W-1:0]   ang_fold;
    logic [Q_W-1:0]     ang_deg;
    logic [RECIP_W-1:0] recip_prod;

    logic               s1_v_reg;
    logic               s1_bank_reg;
    logic               s1_last_reg;
    logic [MAG_W-1:0]   s1_mag_reg;
    logic [ANG_W-1:0]   s1_ang_reg;
    logic [BIN_W-1:0]   s1_bin_reg;

    always_comb
    begin
        if (orientation >= ANG_W'(HALF_TURN))
            ang_fold = orientation - ANG_W'(HALF_TURN);
        else
            ang_fold = orientation;
        ang_deg    = ang_fold[ANG_W-1:FRAC_BITS];
        recip_prod = RECIP_W'(ang_deg) * RECIP_W'(BIN_RECIP);
    end

    // ------------------------------------------------------------------
    // Stage 2: in-bin fraction and bin number modulo nine
    // ------------------------------------------------------------------
    logic [ANG_W-1:0]   bin_base;
    logic [ANG_W-1:0]   frac_full;
    logic [IDX_W-1:0]   bin_mod;

    logic               s2_v_reg;
    logic               s2_bank_reg;
    logic               s2_last_reg;
    logic [MAG_W-1:0]   s2_mag_reg;
    logic [FRAC_W-1:0]  s2_frac_reg;
    logic [IDX_W-1:0]   s2_bin_reg;

    always_comb
    begin
        bin_base  = ANG_W'(s1_bin_reg) * ANG_W'(BIN_SPAN);
        frac_full = s1_ang_reg - bin_base;
        if (s1_bin_reg >= BIN_W'(NUM_BINS))
            bin_mod = IDX_W'(s1_bin_reg - BIN_W'(NUM_BINS));
        else
            bin_mod = IDX_W'(s1_bin_reg);
    end

    // ------------------------------------------------------------------
    // Stage 3: weight multiplies, accumulator read issued
    // ------------------------------------------------------------------
    logic [FRAC_W-1:0]  w_lo;

    logic               s3_v_reg;
    logic               s3_last_reg;
    logic [ADDR_W-1:0]  s3_addr_reg;
    logic [PROD_W-1:0]  s3_lo_reg;
    logic [PROD_W-1:0]  s3_hi_reg;

    assign w_lo = FRAC_W'(BIN_SPAN) - s2_frac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_side_reg <= SIDE_W'(8);
            pix_cnt_reg   <= '0;
            cur_bank_reg  <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                cell_side_reg <= cfg_wr_data;
            if (in_accept)
            begin
                pix_cnt_reg <= pix_cnt_next;
                if (in_last)
                    cur_bank_reg <= !cur_bank_reg;
            end
            s1_v_reg <= in_accept;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_bank_reg <= cur_bank_reg;
        s1_last_reg <= in_last;
        s1_mag_reg  <= magnitude;
        s1_ang_reg  <= ang_fold;
        s1_bin_reg  <= recip_prod[RECIP_SHIFT +: BIN_W];

        s2_bank_reg <= s1_bank_reg;
        s2_last_reg <= s1_last_reg;
        s2_mag_reg  <= s1_mag_reg;
        s2_frac_reg <= frac_full[FRAC_W-1:0];
        s2_bin_reg  <= bin_mod;

        s3_last_reg <= s2_last_reg;
        s3_addr_reg <= {s2_bank_reg, s2_bin_reg};
        s3_lo_reg   <= PROD_W'(s2_mag_reg) * PROD_W'(w_lo);
        s3_hi_reg   <= PROD_W'(s2_mag_reg) * PROD_W'(s2_frac_reg);
    end

    // ------------------------------------------------------------------
    // Accumulator memories. mem_lo[b] collects the share that stays in
    // bin b, mem_hi[b] the share that spills into the bin after b. Both
    // are keyed by the lower bin, so one pixel touches one address.
    // ------------------------------------------------------------------
    logic [ACC_W-1:0]    mem_lo [MEM_DEPTH];
    logic [ACC_W-1:0]    mem_hi [MEM_DEPTH];
    logic [NUM_BINS-1:0] valid_reg [2];

    logic [ACC_W-1:0]    acc_lo_rd_reg, acc_hi_rd_reg;
    logic [ACC_W-1:0]    ro_lo_rd_reg, ro_hi_rd_reg;

    logic                fwd_v_reg;
    logic [ADDR_W-1:0]   fwd_addr_reg;
    logic [ACC_W-1:0]    fwd_lo_reg, fwd_hi_reg;

    logic [ACC_W-1:0]    base_lo, base_hi;
    logic [ACC_W-1:0]    sum_lo, sum_hi;
    logic                s3_bank;
    logic [IDX_W-1:0]    s3_bin;
    logic                fwd_hit;

    // Readout side.
    logic                rd_active_reg;
    logic                rd_bank_reg;
    logic [IDX_W-1:0]    rd_k_reg;
    logic                rd_pend_reg;
    logic                rd_pend_bank_reg;
    logic [IDX_W-1:0]    rd_pend_k_reg;
    logic [IDX_W-1:0]    rd_pend_km1_reg;
    logic [IDX_W-1:0]    rd_km1;
    logic                rd_start;
    logic                rd_issue;
    logic                ro_end;
    logic [ACC_W-1:0]    ro_lo, ro_hi, ro_sum;

    assign s3_bank = s3_addr_reg[ADDR_W-1];
    assign s3_bin  = s3_addr_reg[IDX_W-1:0];
    assign fwd_hit = fwd_v_reg && (fwd_addr_reg == s3_addr_reg);

    always_comb
    begin
        if (fwd_hit)
        begin
            base_lo = fwd_lo_reg;
            base_hi = fwd_hi_reg;
        end
        else if (valid_reg[s3_bank][s3_bin])
        begin
            base_lo = acc_lo_rd_reg;
            base_hi = acc_hi_rd_reg;
        end
        else
        begin
            base_lo = '0;
            base_hi = '0;
        end
        sum_lo = base_lo + ACC_W'(s3_lo_reg);
        sum_hi = base_hi + ACC_W'(s3_hi_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s3_v_reg)
        begin
            mem_lo[s3_addr_reg] <= sum_lo;
            mem_hi[s3_addr_reg] <= sum_hi;
        end
        acc_lo_rd_reg <= mem_lo[{s2_bank_reg, s2_bin_reg}];
        acc_hi_rd_reg <= mem_hi[{s2_bank_reg, s2_bin_reg}];
        ro_lo_rd_reg  <= mem_lo[{rd_bank_reg, rd_k_reg}];
        ro_hi_rd_reg  <= mem_hi[{rd_bank_reg, rd_km1}];
        fwd_addr_reg  <= s3_addr_reg;
        fwd_lo_reg    <= sum_lo;
        fwd_hi_reg    <= sum_hi;
    end

    // ------------------------------------------------------------------
    // Readout: bin k is the kept share of bin k plus the spilled share
    // of the bin before it. Reads run ahead of the output queue only as
    // far as the queue has room.
    // ------------------------------------------------------------------
    logic [ACC_W-1:0]    oq_sum_reg [OQ_DEPTH];
    logic [IDX_W-1:0]    oq_idx_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] oq_wr_reg, oq_rd_reg;
    logic [OQ_PTR_W-1:0] oq_cnt_reg;
    logic                oq_push, oq_pop;
    logic [OQ_PTR_W:0]   oq_load;

    assign rd_km1   = (rd_k_reg == '0) ? LAST_BIN : rd_k_reg - IDX_W'(1);
    assign rd_start = !rd_active_reg && done_reg[rd_bank_reg];
    assign oq_load  = (OQ_PTR_W+1)'(oq_cnt_reg) + (OQ_PTR_W+1)'(rd_pend_reg);
    assign rd_issue = rd_active_reg && (oq_load < (OQ_PTR_W+1)'(OQ_DEPTH));
    assign ro_end   = rd_pend_reg && (rd_pend_k_reg == LAST_BIN);

    assign ro_lo  = valid_reg[rd_pend_bank_reg][rd_pend_k_reg]   ? ro_lo_rd_reg : '0;
    assign ro_hi  = valid_reg[rd_pend_bank_reg][rd_pend_km1_reg] ? ro_hi_rd_reg : '0;
    assign ro_sum = ro_lo + ro_hi;

    assign oq_push = rd_pend_reg;
    assign oq_pop  = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0]  <= '0;
            valid_reg[1]  <= '0;
            bank_full_reg <= '0;
            done_reg      <= '0;
            fwd_v_reg     <= 1'b0;
            rd_active_reg <= 1'b0;
            rd_bank_reg   <= 1'b0;
            rd_k_reg      <= '0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            fwd_v_reg <= s3_v_reg;

            // A bank is claimed by its cell's last pixel and released once
            // its last bin has been read.
            for (int b = 0; b < 2; b++)
            begin
                if (ro_end && (rd_pend_bank_reg == 1'(b)))
                begin
                    valid_reg[b]     <= '0;
                    bank_full_reg[b] <= 1'b0;
                end
                else
                begin
                    if (s3_v_reg && (s3_bank == 1'(b)))
                        valid_reg[b][s3_bin] <= 1'b1;
                    if (in_accept && in_last && (cur_bank_reg == 1'(b)))
                        bank_full_reg[b] <= 1'b1;
                end

                if (rd_start && (rd_bank_reg == 1'(b)))
                    done_reg[b] <= 1'b0;
                else if (s3_v_reg && s3_last_reg && (s3_bank == 1'(b)))
                    done_reg[b] <= 1'b1;
            end

            if (rd_start)
            begin
                rd_active_reg <= 1'b1;
                rd_k_reg      <= '0;
            end
            else if (rd_issue)
            begin
                if (rd_k_reg == LAST_BIN)
                begin
                    rd_active_reg <= 1'b0;
                    rd_bank_reg   <= !rd_bank_reg;
                end
                else
                    rd_k_reg <= rd_k_reg + IDX_W'(1);
            end
            rd_pend_reg <= rd_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_pend_bank_reg <= rd_bank_reg;
        rd_pend_k_reg    <= rd_k_reg;
        rd_pend_km1_reg  <= rd_km1;
        if (oq_push)
        begin
            oq_sum_reg[oq_wr_reg] <= ro_sum;
            oq_idx_reg[oq_wr_reg] <= rd_pend_k_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (oq_push)
                oq_wr_reg <= (oq_wr_reg == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0
                                                                    : oq_wr_reg + OQ_PTR_W'(1);
            if (oq_pop)
                oq_rd_reg <= (oq_rd_reg == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0
                                                                    : oq_rd_reg + OQ_PTR_W'(1);
            if (oq_push && !oq_pop)
                oq_cnt_reg <= oq_cnt_reg + OQ_PTR_W'(1);
            else if (oq_pop && !oq_push)
                oq_cnt_reg <= oq_cnt_reg - OQ_PTR_W'(1);
        end
    end

    assign out_valid = (oq_cnt_reg != '0);
    assign bin_index = oq_idx_reg[oq_rd_reg];
    assign bin_sum   = oq_sum_reg[oq_rd_reg];
    assign last_bin  = (oq_idx_reg[oq_rd_reg] == LAST_BIN);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A pixel never writes into the bank that is being read out.
    a_no_write_during_readout: assert property (@(posedge clk) disable iff (!rst_n)
        s3_v_reg |-> !(rd_active_reg && (rd_bank_reg == s3_bank)))
        else $error("accumulator write hits the bank under readout");

    // The output queue never overflows.
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        oq_push |-> ((oq_cnt_reg != OQ_PTR_W'(OQ_DEPTH)) || oq_pop))
        else $error("result queue overflow");

    // A finished bank is always still claimed until its readout ends.
    a_done_claimed: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg[0] |-> bank_full_reg[0]) and (done_reg[1] |-> bank_full_reg[1]))
        else $error("bank marked finished without being claimed");

    // A new last pixel never lands on a bank whose previous cell waits.
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_v_reg && s3_last_reg) |-> !done_reg[s3_bank])
        else $error("bank finished twice without readout");

endmodule

>>> dv/hog_histogram_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both channels of the histogram unit.
// It keeps its own copy of the nine bin sums and the pixel count, and it
// queues the nine bin reports that each completed cell must produce.
module hog_histogram_checker
    import hog_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [SIDE_W-1:0]   cfg_wr_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [MAG_W-1:0]    magnitude,
    input  logic [ANG_W-1:0]    orientation,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [IDX_W-1:0]    bin_index,
    input  logic [ACC_W-1:0]    bin_sum,
    input  logic                last_bin,
    output int                  mismatch_count,
    output int                  bins_owed
);

    localparam int RESET_CELL_SIDE = 8;
    localparam int MAX_REPORTS     = 10;

    typedef struct {
        logic [IDX_W-1:0] index;
        logic [ACC_W-1:0] sum;
        logic             last;
    } bin_report_t;

    bin_report_t        owed_bins [$];
    logic [ACC_W-1:0]   hist_sums [NUM_BINS];
    logic [CNT_W-1:0]   cell_pixels;
    logic [SIDE_W-1:0]  side_setting;

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // Splits one pixel's magnitude between its two nearest bins and, on the
    // last pixel of a cell, queues the nine bin reports and clears the sums.
    task automatic bin_pixel(input logic [MAG_W-1:0] mag, input logic [ANG_W-1:0] ang);
        logic [ANG_W-1:0] folded;
        int unsigned      coarse;
        int unsigned      frac;
        int               side;
        int               k;
        bin_report_t      report;
        folded = ang;
        if (folded >= ANG_W'(HALF_TURN))
        begin
            folded = folded - ANG_W'(HALF_TURN);
        end
        coarse = folded / BIN_SPAN;
        frac   = folded % BIN_SPAN;
        hist_sums[coarse % NUM_BINS] += ACC_W'(mag) * ACC_W'(BIN_SPAN - frac);
        hist_sums[(coarse + 1) % NUM_BINS] += ACC_W'(mag) * ACC_W'(frac);

        side = side_setting;
        if (side < 1)
        begin
            side = 1;
        end
        if (side > MAX_CELL_SIDE)
        begin
            side = MAX_CELL_SIDE;
        end

        if (int'(cell_pixels) + 1 < side * side)
        begin
            cell_pixels = cell_pixels + 1'b1;
        end
        else
        begin
            for (k = 0; k < NUM_BINS; k++)
            begin
                report.index = IDX_W'(k);
                report.sum   = hist_sums[k];
                report.last  = (k == NUM_BINS - 1);
                owed_bins.push_back(report);
                hist_sums[k] = '0;
            end
            cell_pixels = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bin_report_t want;
        if (!rst_n)
        begin
            owed_bins.delete();
            foreach (hist_sums[k])
            begin
                hist_sums[k] = '0;
            end
            cell_pixels    = '0;
            side_setting   = SIDE_W'(RESET_CELL_SIDE);
            mismatch_count = 0;
            bins_owed      = 0;
        end
        else
        begin
            // Results of a cell leave the block only in a later cycle than the pixel
            // that closes it, so results are checked before new pixels.
            if (out_valid && !out_stall)
            begin
                if (owed_bins.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected result: bin %0d sum %0d last %0b",
                                            bin_index, bin_sum, last_bin));
                end
                else
                begin
                    want = owed_bins.pop_front();
                    if (bin_index !== want.index || bin_sum !== want.sum ||
                        last_bin !== want.last)
                    begin
                        note_mismatch($sformatf(
                            "expected bin %0d sum %0d last %0b, got bin %0d sum %0d last %0b",
                            want.index, want.sum, want.last, bin_index, bin_sum, last_bin));
                    end
                end
            end
            if (cfg_wr_en)
            begin
                side_setting = cfg_wr_data;
            end
            if (in_valid && !in_stall)
            begin
                bin_pixel(magnitude, orientation);
            end
            bins_owed = owed_bins.size();
        end
    end

endmodule

>>> dv/hog_cell_orientation_histogram_unit_test.sv
`timescale 1ns / 1ps

// Top of the histogram unit testbench. This module only creates stimulus
// and gives the verdict; the checker beside the block predicts every bin
// report and compares it with what the block emits.
module hog_cell_orientation_histogram_unit_test
    import hog_pkg::*;
();

    // Cycles to let the pipeline empty before a register write. The first
    // result of a cell shows up only after its last pixel has left the
    // pipeline, and a partial cell produces nothing we could wait for.
    localparam int PIPE_SETTLE   = 20;
    localparam int MAX_GAP       = 19;
    localparam int RANDOM_PIXELS = 30;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [SIDE_W-1:0]  cfg_wr_data;
    logic               in_valid;
    logic               in_stall;
    logic [MAG_W-1:0]   magnitude;
    logic [ANG_W-1:0]   orientation;
    logic               out_valid;
    logic               out_stall;
    logic [IDX_W-1:0]   bin_index;
    logic [ACC_W-1:0]   bin_sum;
    logic               last_bin;

    int                 mismatch_count;
    int                 bins_owed;

    // When a burst flag is set, that side of the block neither idles nor
    // stalls, so back-to-back transactions are covered as well.
    logic               src_burst;
    logic               sink_burst;
    logic               result_taken;
    int                 sink_hold;

    hog_cell_orientation_histogram_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .magnitude   (magnitude),
        .orientation (orientation),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .bin_index   (bin_index),
        .bin_sum     (bin_sum),
        .last_bin    (last_bin)
    );

    hog_histogram_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .magnitude      (magnitude),
        .orientation    (orientation),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .bin_index      (bin_index),
        .bin_sum        (bin_sum),
        .last_bin       (last_bin),
        .mismatch_count (mismatch_count),
        .bins_owed      (bins_owed)
    );

    always #6 clk = ~clk;

    // The result side. After every result it takes, the sink draws how many
    // cycles it holds stall high before the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_taken <= 1'b0;
        end
        else
        begin
            result_taken <= out_valid && !out_stall;
        end
    end

    always @(negedge clk)
    begin
        if (result_taken)
        begin
            sink_hold = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
        end
        if (sink_hold != 0)
        begin
            out_stall <= 1'b1;
            sink_hold--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Draws one pixel. Most are uniform over the legal angle range, but bin
    // edges, the last step below an edge, angles of 360 degrees and above,
    // and the magnitude extremes each get a share of their own.
    task automatic make_pixel(output logic [MAG_W-1:0] mag, output logic [ANG_W-1:0] ang);
        case ($urandom_range(0, 9))
            0:       mag = '0;
            1:       mag = '1;
            default: mag = MAG_W'($urandom);
        endcase
        case ($urandom_range(0, 11))
            0:       ang = ANG_W'($urandom_range(0, 17) * BIN_SPAN);
            1:       ang = ANG_W'($urandom_range(0, 17) * BIN_SPAN + BIN_SPAN - 1);
            2:       ang = ANG_W'($urandom_range(2 * HALF_TURN, (1 << ANG_W) - 1));
            default: ang = ANG_W'($urandom_range(0, 2 * HALF_TURN - 1));
        endcase
    endtask

    // Sends one pixel transaction. It is entered and left at a falling edge,
    // and it idles for a random number of cycles first unless in a burst.
    task automatic send_pixel(input logic [MAG_W-1:0] mag, input logic [ANG_W-1:0] ang);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        magnitude   <= mag;
        orientation <= ang;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        @(negedge clk);
    endtask

    // Waits until every queued bin report has arrived, then lets the
    // pipeline empty so a register write finds the block idle.
    task automatic drain_histograms();
        in_valid <= 1'b0;
        while (bins_owed != 0)
        begin
            @(negedge clk);
        end
        repeat (PIPE_SETTLE) @(negedge clk);
    endtask

    task automatic write_cell_side(input logic [SIDE_W-1:0] side);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= side;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        logic [MAG_W-1:0] mag;
        logic [ANG_W-1:0] ang;
        int               side;
        int               cells;
        int               sent;
        int               i;

        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        magnitude    = '0;
        orientation  = '0;
        out_stall    = 1'b0;
        src_burst    = 1'b0;
        sink_burst   = 1'b0;
        sink_hold    = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // One full cell at the reset side of eight.
        for (i = 0; i < 64; i++)
        begin
            make_pixel(mag, ang);
            send_pixel(mag, ang);
        end

        // A side of zero acts as one, so every pixel below closes a cell and
        // its split across the two bins is seen on its own.
        drain_histograms();
        write_cell_side('0);
        send_pixel('0, '0);
        send_pixel('1, '0);
        send_pixel('1, ANG_W'(BIN_SPAN - 1));
        send_pixel('1, ANG_W'(BIN_SPAN));
        send_pixel(MAG_W'(1), ANG_W'(HALF_TURN - 1));
        send_pixel('1, ANG_W'(HALF_TURN - 1));
        send_pixel('1, ANG_W'(HALF_TURN));
        send_pixel('1, ANG_W'(2 * HALF_TURN - 1));
        // At 360 degrees and above the single fold leaves bins past eight,
        // which wrap around modulo nine.
        send_pixel('1, ANG_W'(2 * HALF_TURN));
        send_pixel('1, '1);
        send_pixel('0, '1);

        // Shrink the cell in the middle of a large one: the count is kept,
        // so the first pixel after the write closes the cell.
        drain_histograms();
        write_cell_side(SIDE_W'(MAX_CELL_SIDE));
        for (i = 0; i < 6; i++)
        begin
            make_pixel(mag, ang);
            send_pixel(mag, ang);
        end
        drain_histograms();
        write_cell_side(SIDE_W'(2));
        for (i = 0; i < 5; i++)
        begin
            make_pixel(mag, ang);
            send_pixel(mag, ang);
        end

        // Random phases with small cells and random idling on both sides.
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            drain_histograms();
            side       = $urandom_range(1, 4);
            cells      = (side > 3) ? 1 : $urandom_range(1, 3);
            src_burst  = ($urandom_range(0, 3) == 0);
            sink_burst = ($urandom_range(0, 3) == 0);
            write_cell_side(SIDE_W'(side));
            repeat (cells * side * side)
            begin
                make_pixel(mag, ang);
                send_pixel(mag, ang);
            end
            sent += cells * side * side;
        end

        // All ones in the register means a side above the maximum, which is
        // clamped to 64, so a handful of pixels closes nothing. A side of one
        // afterwards closes the cell on the next pixel with all of them in it.
        drain_histograms();
        src_burst  = 1'b0;
        sink_burst = 1'b0;
        write_cell_side('1);
        for (i = 0; i < 8; i++)
        begin
            make_pixel(mag, ang);
            send_pixel(mag, ang);
        end
        drain_histograms();
        write_cell_side(SIDE_W'(1));
        make_pixel(mag, ang);
        send_pixel(mag, ang);

        drain_histograms();
        if (mismatch_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #12_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
